### rtl/qpsc_pkg.sv
package qpsc_pkg;

	localparam int FRAC_BITS = 8;

	localparam logic [1:0] REQ_SAMPLE  = 2'd0;
	localparam logic [1:0] REQ_TICK    = 2'd1;
	localparam logic [1:0] REQ_CLR_POS = 2'd2;
	localparam logic [1:0] REQ_CLR_INT = 2'd3;

	localparam logic [1:0] REG_TARGET = 2'd0;
	localparam logic [1:0] REG_KP     = 2'd1;
	localparam logic [1:0] REG_KI     = 2'd2;
	localparam logic [1:0] REG_CPR    = 2'd3;

	localparam logic [15:0] KP_RESET  = 16'd435;
	localparam logic [15:0] KI_RESET  = 16'd896;
	localparam logic [15:0] CPR_RESET = 16'd500;

	localparam logic [25:0] US_PER_MIN = 26'd60000000;
	localparam logic [31:0] INC_DEN    = 32'(64'd1000000 << FRAC_BITS);
	localparam logic [61:0] INC_HALF   = 62'(64'd1000000 << (FRAC_BITS - 1));

	localparam logic signed [23:0] SPD_MAX  = 24'sh7fffff;
	localparam logic signed [23:0] SPD_MIN  = 24'sh800000;
	localparam logic signed [23:0] DEAD_LIM = 24'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [17:0] DRV_LIM  = 18'sd65280;

	localparam int DIV_STEPS = 23;

	localparam logic signed [1:0] QUAD_STEP [16] = '{
		2'sd0, -2'sd1, 2'sd1, 2'sd0,
		2'sd1, 2'sd0, 2'sd0, -2'sd1,
		-2'sd1, 2'sd0, 2'sd0, 2'sd1,
		2'sd0, 2'sd1, -2'sd1, 2'sd0
	};

	typedef enum logic [3:0] {
		S_IDLE, S_DEN, S_NUM, S_SDIV, S_DIV, S_RAW, S_FILT, S_ERR,
		S_KP, S_KIEL, S_KIERR, S_IDIV, S_INC, S_OUT, S_FIN
	} state_t;

endpackage

### rtl/quadrature_pi_speed_controller.sv
// Quadrature PI speed controller. Every request gives exactly one result holding the
// position, speeds, error, integral and drive after that request. Encoder samples and the
// two clear requests go straight to the finish state. A control tick passes through one
// shared 23-step radix-2 divider for the speed estimate and, when the target lies outside
// the deadband, once more for the integral increment; it also uses one shared 33x28
// multiplier. in_stall stays high while a request is being worked on; a finished
// result waits in the output register while the next request is taken.
module quadrature_pi_speed_controller #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [23:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          req_type,
	input  logic                enc_a,
	input  logic                enc_b,
	input  logic [15:0]         elapsed_us,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  position,
	output logic signed [23:0]  raw_speed,
	output logic signed [23:0]  filtered_speed,
	output logic signed [23:0]  speed_error,
	output logic signed [16:0]  integral_value,
	output logic signed [8:0]   drive_command,
	output logic [7:0]          pwm_duty,
	output logic                direction
);
	import qpsc_pkg::*;

	localparam int MW = (COUNT_WIDTH > 27) ? COUNT_WIDTH : 27;
	localparam int PW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
	localparam logic [MW-1:0] MAG_LIM = MW'(1) << 26;

	state_t state_q, state_d;

	logic [23:0] target_q;
	logic [15:0] kp_q, ki_q, cpr_q;

	logic [1:0]              last_ab_q;
	logic [COUNT_WIDTH-1:0]  pos_q, tick_q;
	logic signed [23:0]      filt_q, raw_q, err_q;
	logic signed [17:0]      integ_q;
	logic signed [8:0]       drive_q;
	logic                    dir_q;

	logic [15:0]         el_q;
	logic [31:0]         den_q, rem_q;
	logic [22:0]         nlow_q, quot_q;
	logic                sat_q, div_spd_q, sneg_q;
	logic [4:0]          cnt_q;
	logic signed [33:0]  p_q;
	logic signed [60:0]  prod_q;

	logic                out_valid_q, dir_out_q;
	logic [31:0]         position_q;
	logic signed [23:0]  raw_out_q, filt_out_q, err_out_q;
	logic signed [16:0]  integ_out_q;
	logic signed [8:0]   drive_out_q;
	logic [7:0]          duty_out_q;

	// combinational datapath
	logic                    accept, load_out;
	logic [15:0]             cpr_eff;
	logic [COUNT_WIDTH-1:0]  d, dmag, step_x;
	logic [MW-1:0]           dmag_x;
	logic [26:0]             mag27;
	logic signed [1:0]       qstep;
	logic [1:0]              cur_ab;
	logic [PW-1:0]           pos_x;
	logic signed [32:0]      mul_a;
	logic signed [27:0]      mul_b;
	logic [60:0]             prod_mag;
	logic [61:0]             div_n;
	logic [31:0]             div_d;
	logic                    div_sat;
	logic [32:0]             r2;
	logic                    r_ge;
	logic signed [23:0]      raw_new;
	logic signed [26:0]      fsum;
	logic [26:0]             fsum_mag;
	logic [24:0]             fmag;
	logic signed [23:0]      filt_new, tgt;
	logic                    tgt_dead, filt_dead;
	logic signed [24:0]      diff;
	logic signed [23:0]      err_new;
	logic [60:0]             pmag;
	logic [23:0]             inc_mag;
	logic signed [24:0]      inc;
	logic signed [25:0]      cand_raw;
	logic signed [17:0]      cand;
	logic signed [34:0]      c_out, o_sum;
	logic                    err_pos, err_neg, keep;
	logic signed [17:0]      o_cl;
	logic [16:0]             o_mag;
	logic [8:0]              duty9;
	logic [7:0]              duty;

	assign accept   = in_valid && !in_stall;
	assign load_out = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	assign cpr_eff = (cpr_q == 16'd0) ? 16'd1 : cpr_q;
	assign d       = tick_q - pos_q;
	assign dmag    = d[COUNT_WIDTH-1] ? (~d + COUNT_WIDTH'(1)) : d;
	assign dmag_x  = MW'(dmag);
	assign mag27   = (dmag_x > MAG_LIM) ? 27'(MAG_LIM) : 27'(dmag_x);

	assign cur_ab = {enc_a, enc_b};
	assign qstep  = QUAD_STEP[{last_ab_q, cur_ab}];
	assign step_x = {{(COUNT_WIDTH-2){qstep[1]}}, qstep};
	assign pos_x  = PW'(pos_q);

	assign prod_mag = prod_q[60] ? (~prod_q + 61'd1) : prod_q;

	// divider
	always_comb begin
		if (state_q == S_IDIV) begin
			div_n = 62'(prod_mag) + INC_HALF;
			div_d = INC_DEN;
		end else begin
			div_n = 62'(prod_mag[52:0]) << FRAC_BITS;
			div_d = den_q;
		end
	end
	assign div_sat = div_n[61:23] >= 39'(div_d);
	assign r2      = {rem_q, nlow_q[22]};
	assign r_ge    = r2 >= {1'b0, den_q};

	// speed and filter
	assign raw_new = sat_q ? (sneg_q ? SPD_MIN : SPD_MAX)
		: (sneg_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q}));
	assign fsum     = 27'(raw_q) + (27'(filt_q) <<< 1) + 27'(filt_q);
	assign fsum_mag = fsum[26] ? (~fsum + 27'd1) : fsum;
	assign fmag     = 25'((fsum_mag + 27'd2) >> 2);
	assign filt_new = fsum[26] ? -$signed(24'(fmag)) : $signed(24'(fmag));
	assign tgt       = $signed(target_q);
	assign tgt_dead  = (tgt > -DEAD_LIM) && (tgt < DEAD_LIM);
	assign filt_dead = (filt_new > -DEAD_LIM) && (filt_new < DEAD_LIM);
	assign diff      = 25'(tgt) - 25'(filt_q);
	assign err_new   = (diff[24] != diff[23]) ? (diff[24] ? SPD_MIN : SPD_MAX) : diff[23:0];

	// pi law
	assign pmag     = (prod_mag + 61'd128) >> 8;
	assign inc_mag  = sat_q ? 24'h800000 : {1'b0, quot_q};
	assign inc      = sneg_q ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
	assign cand_raw = 26'(integ_q) + 26'(inc);
	assign cand     = (cand_raw > 26'(DRV_LIM)) ? DRV_LIM
		: ((cand_raw < -26'(DRV_LIM)) ? -DRV_LIM : 18'(cand_raw));
	assign c_out    = 35'(p_q) + 35'(cand);
	assign err_neg  = err_q[23];
	assign err_pos  = !err_q[23] && (err_q != 24'sd0);
	assign keep     = ((c_out > -35'(DRV_LIM)) && (c_out < 35'(DRV_LIM)))
		|| ((c_out >= 35'(DRV_LIM)) && err_neg)
		|| ((c_out <= -35'(DRV_LIM)) && err_pos);
	assign o_sum    = 35'(p_q) + 35'(integ_q);
	assign o_cl     = (o_sum > 35'(DRV_LIM)) ? DRV_LIM
		: ((o_sum < -35'(DRV_LIM)) ? -DRV_LIM : 18'(o_sum));
	assign o_mag    = o_cl[17] ? 17'(-o_cl) : 17'(o_cl);
	assign duty9    = 9'((18'(o_mag) + 18'd128) >> 8);
	assign duty     = (duty9 > 9'd255) ? 8'd255 : duty9[7:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = (req_type == REQ_TICK) ? S_DEN : S_FIN;
			end
			S_DEN:   state_d = S_NUM;
			S_NUM:   state_d = S_SDIV;
			S_SDIV:  state_d = S_DIV;
			S_DIV: begin
				if (cnt_q == 5'd0) state_d = div_spd_q ? S_RAW : S_INC;
			end
			S_RAW:   state_d = S_FILT;
			S_FILT:  state_d = tgt_dead ? S_FIN : S_ERR;
			S_ERR:   state_d = S_KP;
			S_KP:    state_d = S_KIEL;
			S_KIEL:  state_d = S_KIERR;
			S_KIERR: state_d = S_IDIV;
			S_IDIV:  state_d = S_DIV;
			S_INC:   state_d = S_OUT;
			S_OUT:   state_d = S_FIN;
			S_FIN: begin
				if (load_out) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != S_IDLE);
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			S_DEN: begin
				mul_a = $signed(33'(el_q));
				mul_b = $signed(28'(cpr_eff));
			end
			S_NUM: begin
				mul_a = $signed(33'(US_PER_MIN));
				mul_b = $signed({1'b0, mag27});
			end
			S_KP: begin
				mul_a = $signed(33'(kp_q));
				mul_b = 28'(err_q);
			end
			S_KIEL: begin
				mul_a = $signed(33'(ki_q));
				mul_b = $signed(28'(el_q));
			end
			S_KIERR: begin
				mul_a = $signed({1'b0, prod_q[31:0]});
				mul_b = 28'(err_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			target_q <= '0;
			kp_q     <= KP_RESET;
			ki_q     <= KI_RESET;
			cpr_q    <= CPR_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TARGET: target_q <= cfg_data;
					REG_KP:     kp_q <= cfg_data[15:0];
					REG_KI:     ki_q <= cfg_data[15:0];
					REG_CPR:    cpr_q <= cfg_data[15:0];
					default:    target_q <= target_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ab_q <= '0;
			pos_q     <= '0;
			tick_q    <= '0;
			filt_q    <= '0;
			raw_q     <= '0;
			err_q     <= '0;
			integ_q   <= '0;
			drive_q   <= '0;
			dir_q     <= 1'b0;
		end else begin
			if (accept) begin
				case (req_type)
					REQ_SAMPLE: begin
						pos_q     <= pos_q + step_x;
						last_ab_q <= cur_ab;
					end
					REQ_CLR_POS: begin
						pos_q  <= '0;
						tick_q <= '0;
					end
					REQ_CLR_INT: begin
						integ_q <= '0;
						err_q   <= '0;
						drive_q <= '0;
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				S_RAW: begin
					raw_q  <= raw_new;
					tick_q <= pos_q;
				end
				S_FILT: begin
					filt_q <= (tgt_dead && filt_dead) ? 24'sd0 : filt_new;
					if (tgt_dead) begin
						integ_q <= '0;
						err_q   <= '0;
						drive_q <= '0;
					end
				end
				S_ERR: err_q <= err_new;
				S_INC: begin
					if (keep) integ_q <= cand;
				end
				S_OUT: begin
					if (o_cl > 18'sd0) begin
						dir_q   <= 1'b1;
						drive_q <= $signed({1'b0, duty});
					end else if (o_cl < 18'sd0) begin
						dir_q   <= 1'b0;
						drive_q <= -$signed({1'b0, duty});
					end else begin
						drive_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) el_q <= (elapsed_us == 16'd0) ? 16'd1 : elapsed_us;
		case (state_q)
			S_NUM: begin
				den_q  <= prod_q[31:0];
				sneg_q <= d[COUNT_WIDTH-1];
			end
			S_SDIV, S_IDIV: begin
				den_q     <= div_d;
				sat_q     <= div_sat;
				rem_q     <= div_n[54:23];
				nlow_q    <= div_n[22:0];
				cnt_q     <= 5'(DIV_STEPS - 1);
				div_spd_q <= (state_q == S_SDIV);
				if (state_q == S_IDIV) sneg_q <= prod_q[60];
			end
			S_DIV: begin
				rem_q  <= r_ge ? 32'(r2 - {1'b0, den_q}) : r2[31:0];
				quot_q <= {quot_q[21:0], r_ge};
				nlow_q <= {nlow_q[21:0], 1'b0};
				cnt_q  <= cnt_q - 5'd1;
			end
			S_KIEL: p_q <= prod_q[60] ? -$signed(34'(pmag)) : $signed(34'(pmag));
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			position_q  <= pos_x[31:0];
			raw_out_q   <= raw_q;
			filt_out_q  <= filt_q;
			err_out_q   <= err_q;
			integ_out_q <= integ_q[16:0];
			drive_out_q <= drive_q;
			duty_out_q  <= drive_q[8] ? 8'(-drive_q) : drive_q[7:0];
			dir_out_q   <= dir_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign position       = position_q;
	assign raw_speed      = raw_out_q;
	assign filtered_speed = filt_out_q;
	assign speed_error    = err_out_q;
	assign integral_value = integ_out_q;
	assign drive_command  = drive_out_q;
	assign pwm_duty       = duty_out_q;
	assign direction      = dir_out_q;

endmodule

### rtl/qpsc_checker.sv
module qpsc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] position,
	input logic signed [16:0] integral_value,
	input logic signed [8:0]  drive_command,
	input logic [7:0]         pwm_duty,
	input logic               direction
);
	logic [7:0] drive_mag;

	assign drive_mag = drive_command[8] ? 8'(-drive_command) : drive_command[7:0];

	// duty is the drive magnitude
	a_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pwm_duty == drive_mag)
		else $error("duty does not match drive");

	// nonzero drive sets direction
	a_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_command != 9'sd0 |-> direction == !drive_command[8])
		else $error("direction disagrees with drive");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

	// integral within clamp
	a_integ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> integral_value <= 17'sd65280 && integral_value >= -17'sd65280)
		else $error("integral out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position))
		else $error("stalled result changed");

endmodule

bind quadrature_pi_speed_controller qpsc_checker u_qpsc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.position       (position),
	.integral_value (integral_value),
	.drive_command  (drive_command),
	.pwm_duty       (pwm_duty),
	.direction      (direction)
);

### tb/testbench.sv
module testbench;
	import qpsc_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [23:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [1:0] req_type;
	logic enc_a;
	logic enc_b;
	logic [15:0] elapsed_us;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] position;
	logic signed [23:0] raw_speed;
	logic signed [23:0] filtered_speed;
	logic signed [23:0] speed_error;
	logic signed [16:0] integral_value;
	logic signed [8:0] drive_command;
	logic [7:0] pwm_duty;
	logic direction;

	typedef struct packed {
		logic [31:0] pos;
		logic [23:0] raw;
		logic [23:0] filt;
		logic [23:0] err;
		logic [16:0] integ;
		logic [8:0] drv;
		logic [7:0] duty;
		logic dir;
	} status_t;

	status_t status_q[$];
	int errors;
	int send_idle_pct;
	int recv_stall_pct;

	// controller model state
	logic [23:0] m_target;
	logic [15:0] m_kp, m_ki, m_cpr;
	logic [1:0] m_last_ab;
	logic [31:0] m_pos, m_tick_pos;
	longint m_filt, m_integ, m_raw, m_err, m_drv;
	logic m_dir;

	quadrature_pi_speed_controller DUT (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint clampv(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint round_div(longint num, longint den);
		longint q;
		q = (mag(num) + den / 2) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic longint speed_from_counts(longint el);
		logic [31:0] d;
		logic neg;
		longint unsigned m, den, n, q1, r, v;
		d = m_tick_pos - m_pos;
		neg = d[31];
		m = neg ? longint'(32'(-d)) : longint'(d);
		if (neg && d == 32'h8000_0000)
			m = 64'h8000_0000;
		den = (el == 0 ? 1 : el) * (m_cpr == 0 ? 1 : m_cpr);
		if (m > (64'd1 << 26))
			m = 64'd1 << 26;
		n = m * 60000000;
		q1 = n / den;
		r = n % den;
		if (q1 >= (64'd1 << 23))
			v = 64'd1 << 23;
		else
			v = (q1 << 8) + ((r << 8) / den);
		if (neg)
			return v > 8388608 ? -8388608 : -longint'(v);
		return v > 8388607 ? 8388607 : longint'(v);
	endfunction

	task automatic predict_status(logic [1:0] kind, logic a, logic b, logic [15:0] el);
		int idx;
		longint tgt, e, p, inc, cand, c_out, o, du, elv;
		status_t s;
		case (kind)
			REQ_SAMPLE: begin
				idx = {m_last_ab, a, b};
				m_pos = m_pos + 32'(signed'(QUAD_STEP[idx]));
				m_last_ab = {a, b};
			end
			REQ_TICK: begin
				elv = el == 0 ? 1 : el;
				m_raw = speed_from_counts(el);
				m_tick_pos = m_pos;
				m_filt = round_div(m_raw + 3 * m_filt, 4);
				tgt = longint'(signed'(m_target));
				if (mag(tgt) < 128) begin
					if (mag(m_filt) < 128)
						m_filt = 0;
					m_integ = 0;
					m_err = 0;
					m_drv = 0;
				end else begin
					e = clampv(tgt - m_filt, -8388608, 8388607);
					m_err = e;
					p = round_div(longint'(m_kp) * e, 256);
					inc = round_div(longint'(m_ki) * e * elv, 256000000);
					cand = clampv(m_integ + inc, -65280, 65280);
					c_out = p + cand;
					if ((c_out > -65280 && c_out < 65280) || (c_out >= 65280 && e < 0)
							|| (c_out <= -65280 && e > 0))
						m_integ = cand;
					o = clampv(p + m_integ, -65280, 65280);
					du = (mag(o) + 128) >> 8;
					if (du > 255)
						du = 255;
					if (o > 0) begin
						m_dir = 1'b1;
						m_drv = du;
					end else if (o < 0) begin
						m_dir = 1'b0;
						m_drv = -du;
					end else begin
						m_drv = 0;
					end
				end
			end
			REQ_CLR_POS: begin
				m_pos = '0;
				m_tick_pos = '0;
			end
			default: begin
				m_integ = 0;
				m_err = 0;
				m_drv = 0;
			end
		endcase
		s.pos = m_pos;
		s.raw = 24'(m_raw);
		s.filt = 24'(m_filt);
		s.err = 24'(m_err);
		s.integ = 17'(m_integ);
		s.drv = 9'(m_drv);
		s.duty = 8'(mag(m_drv));
		s.dir = m_dir;
		status_q.push_back(s);
	endtask

	task automatic send_request(logic [1:0] kind, logic a, logic b, logic [15:0] el);
		cfg_we <= 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		enc_a <= a;
		enc_b <= b;
		elapsed_us <= el;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_status(kind, a, b, el);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		in_valid <= 1'b0;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_TARGET: m_target = val;
			REG_KP: m_kp = val[15:0];
			REG_KI: m_ki = val[15:0];
			default: m_cpr = val[15:0];
		endcase
	endtask

	task automatic drain;
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		cfg_we <= 1'b0;
		while (status_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (80)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		status_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {position, raw_speed, filtered_speed, speed_error, integral_value,
				drive_command, pwm_duty, direction};
			if (status_q.size() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				errors++;
			end else begin
				want = status_q.pop_front();
				if (got.pos != want.pos) begin
					$display("%0t position exp %h got %h", $time, want.pos, got.pos);
					errors++;
				end
				if (got.raw != want.raw) begin
					$display("%0t raw_speed exp %h got %h", $time, want.raw, got.raw);
					errors++;
				end
				if (got.filt != want.filt) begin
					$display("%0t filtered exp %h got %h", $time, want.filt, got.filt);
					errors++;
				end
				if (got.err != want.err) begin
					$display("%0t error exp %h got %h", $time, want.err, got.err);
					errors++;
				end
				if (got.integ != want.integ) begin
					$display("%0t integral exp %h got %h", $time, want.integ, got.integ);
					errors++;
				end
				if (got.drv != want.drv) begin
					$display("%0t drive exp %h got %h", $time, want.drv, got.drv);
					errors++;
				end
				if (got.duty != want.duty) begin
					$display("%0t duty exp %h got %h", $time, want.duty, got.duty);
					errors++;
				end
				if (got.dir != want.dir) begin
					$display("%0t direction exp %h got %h", $time, want.dir, got.dir);
					errors++;
				end
			end
		end
	end

	// walk the encoder forward or backward n steps
	task automatic spin(int n, bit fwd);
		logic [1:0] ab;
		for (int i = 0; i < n; i++) begin
			ab = m_last_ab;
			case (ab)
				2'b00: ab = fwd ? 2'b01 : 2'b10;
				2'b01: ab = fwd ? 2'b11 : 2'b00;
				2'b11: ab = fwd ? 2'b10 : 2'b01;
				default: ab = fwd ? 2'b00 : 2'b11;
			endcase
			send_request(REQ_SAMPLE, ab[1], ab[0], 16'($urandom));
		end
	endtask

	task automatic test_directed;
		for (int i = 0; i < 16; i++) begin
			send_request(REQ_SAMPLE, i[1], i[0], 16'hffff);
			send_request(REQ_SAMPLE, i[3], i[2], 16'h0000);
		end
		send_request(REQ_TICK, 0, 0, 16'd10000);
		drain();
		write_reg(REG_TARGET, 24'd25600);
		spin(5, 1);
		send_request(REQ_TICK, 1, 1, 16'd0);
		send_request(REQ_TICK, 0, 0, 16'hffff);
		send_request(REQ_TICK, 0, 0, 16'd1);
		send_request(REQ_CLR_INT, 1, 1, 16'hffff);
		send_request(REQ_CLR_POS, 1, 0, 16'h5555);
		send_request(REQ_TICK, 0, 1, 16'haaaa);
		drain();
	endtask

	task automatic test_config_sweep;
		logic [23:0] tgts[6];
		tgts = '{24'h7fffff, 24'h800000, 24'd127, 24'hffff81, 24'd128, 24'hffff80};
		for (int k = 0; k < 6; k++) begin
			write_reg(REG_TARGET, tgts[k]);
			write_reg(REG_KP, k[0] ? 24'hffff : 24'd0);
			write_reg(REG_KI, k[1] ? 24'hffff : 24'd0);
			write_reg(REG_CPR, k == 2 ? 24'd0 : (k[0] ? 24'd1 : 24'hffff));
			spin($urandom_range(40), k[0]);
			send_request(REQ_TICK, 0, 0, k[0] ? 16'd1 : 16'hffff);
			send_request(REQ_TICK, 0, 0, 16'($urandom));
			drain();
		end
	endtask

	task automatic test_random(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 55)
				spin($urandom_range(1, 6), $urandom_range(1));
			else if (r < 70)
				send_request(REQ_SAMPLE, $urandom_range(1), $urandom_range(1), 16'($urandom));
			else if (r < 90)
				send_request(REQ_TICK, $urandom_range(1), $urandom_range(1),
					$urandom_range(7) == 0 ? 16'($urandom) : 16'($urandom_range(50, 20000)));
			else if (r < 95)
				send_request(REQ_CLR_POS, $urandom_range(1), $urandom_range(1), 16'($urandom));
			else
				send_request(REQ_CLR_INT, $urandom_range(1), $urandom_range(1), 16'($urandom));
		end
		drain();
		write_reg(REG_TARGET, 24'($urandom));
		write_reg(REG_KP, 24'($urandom_range(65535)));
		write_reg(REG_KI, 24'($urandom_range(65535)));
		write_reg(REG_CPR, 24'($urandom_range(1, 2000)));
	endtask

	task automatic test_idling;
		int sp[4];
		int rp[4];
		sp = '{0, 57, 0, 31};
		rp = '{0, 0, 57, 31};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = sp[ph];
			recv_stall_pct = rp[ph];
			test_random(35);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_SAMPLE;
		enc_a = 1'b0;
		enc_b = 1'b0;
		elapsed_us = '0;
		m_target = '0;
		m_kp = KP_RESET;
		m_ki = KI_RESET;
		m_cpr = CPR_RESET;
		m_last_ab = '0;
		m_pos = '0;
		m_tick_pos = '0;
		m_filt = 0;
		m_integ = 0;
		m_raw = 0;
		m_err = 0;
		m_drv = 0;
		m_dir = 1'b0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_idling();
		write_reg(REG_TARGET, 24'hfff000);
		write_reg(REG_CPR, 24'd64);
		test_idling();
		drain();
		if (errors == 0 && status_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end
endmodule

### files.f
rtl/qpsc_pkg.sv
rtl/quadrature_pi_speed_controller.sv
rtl/qpsc_checker.sv
tb/testbench.sv
